[rtl/scsplit_pkg.sv]
package scsplit_pkg;

  // Record geometry
  localparam int RECORD_LENGTH = 45;
  localparam int FILL_W        = $clog2(RECORD_LENGTH + 1);

  // Byte positions inside a record
  localparam int TYPE_POS    = 0;
  localparam int COUNTER_POS = 7;
  localparam int VALUE_POS   = 13;
  localparam int TLO_POS     = 29;
  localparam int THI_POS     = 33;

  // Start code detection
  localparam logic [23:0] START_PREFIX = 24'h000001;
  localparam logic [23:0] RECENT_RESET = 24'hADBEEF;
  localparam int          HEADER_TELEMETRY_BIT = 7;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_VIDEO      = 3'd0,
    KIND_ABSORBED   = 3'd1,
    KIND_COMPLETE   = 3'd2,
    KIND_MISALIGNED = 3'd3,
    KIND_DISCARDED  = 3'd4
  } kind_t;

  // Classified byte handed from front to back
  typedef struct packed {
    kind_t              kind;
    logic [7:0]         data_byte;
    logic               unit_start;
    logic               incomplete_dropped;
    logic [FILL_W-1:0]  pos;
  } item_t;

endpackage

[rtl/scsplit_if.sv]
interface scsplit_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface scsplit_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data_byte;
  logic        unit_start;
  logic        incomplete_dropped;
  logic [7:0]  record_type;
  logic [7:0]  record_counter;
  logic [31:0] record_value;
  logic [31:0] record_time_low;
  logic [31:0] record_time_high;

  modport source (output valid, output kind, output data_byte, output unit_start,
                  output incomplete_dropped, output record_type, output record_counter,
                  output record_value, output record_time_low, output record_time_high,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input unit_start,
                  input incomplete_dropped, input record_type, input record_counter,
                  input record_value, input record_time_low, input record_time_high,
                  output ready);
endinterface

[rtl/scsplit_front.sv]
module scsplit_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          stream_byte,
  output scsplit_pkg::item_t  item
);

  logic [23:0]                    recent_r, recent_nxt;
  logic                           mode_r, mode_nxt;
  logic [scsplit_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic                           err_r, err_nxt;

  logic                           start;
  logic                           mode_eff;
  logic                           err_eff;
  logic [scsplit_pkg::FILL_W-1:0] fill_eff;
  logic [scsplit_pkg::FILL_W-1:0] pos;
  logic [scsplit_pkg::FILL_W-1:0] fill_inc;

  // Classify the incoming byte against the current unit state
  always_comb begin
    start      = (recent_r == scsplit_pkg::START_PREFIX);
    recent_nxt = {recent_r[15:0], stream_byte};
    mode_eff   = start ? stream_byte[scsplit_pkg::HEADER_TELEMETRY_BIT] : mode_r;
    err_eff    = start ? 1'b0 : err_r;
    fill_eff   = start ? '0 : fill_r;
    pos        = (fill_eff >= scsplit_pkg::FILL_W'(scsplit_pkg::RECORD_LENGTH)) ?
                 '0 : fill_eff;
    fill_inc   = pos + 1'b1;

    mode_nxt = mode_eff;
    err_nxt  = err_eff;
    fill_nxt = fill_eff;

    item.data_byte          = stream_byte;
    item.unit_start         = start;
    item.incomplete_dropped = start && mode_r && (fill_r != '0);
    item.pos                = pos;
    item.kind               = scsplit_pkg::KIND_VIDEO;

    if (!mode_eff) begin
      item.kind = scsplit_pkg::KIND_VIDEO;
    end else if (err_eff) begin
      item.kind = scsplit_pkg::KIND_DISCARDED;
    end else if (fill_inc == scsplit_pkg::FILL_W'(scsplit_pkg::RECORD_LENGTH)) begin
      // last record byte: the record tail is the last three stream bytes
      fill_nxt = '0;
      if (recent_nxt == scsplit_pkg::START_PREFIX) begin
        item.kind = scsplit_pkg::KIND_COMPLETE;
      end else begin
        item.kind = scsplit_pkg::KIND_MISALIGNED;
        err_nxt   = 1'b1;
      end
    end else begin
      fill_nxt  = fill_inc;
      item.kind = scsplit_pkg::KIND_ABSORBED;
    end
  end

  // Unit state advances on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r <= scsplit_pkg::RECENT_RESET;
      mode_r   <= 1'b0;
      fill_r   <= '0;
      err_r    <= 1'b0;
    end else if (accept) begin
      recent_r <= recent_nxt;
      mode_r   <= mode_nxt;
      fill_r   <= fill_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

[rtl/scsplit_queue.sv]
module scsplit_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  scsplit_pkg::item_t  push_item,
  input  logic                pop,
  output scsplit_pkg::item_t  head_item,
  output logic                not_empty,
  output logic                not_full
);

  scsplit_pkg::item_t                  slot_r [scsplit_pkg::QUEUE_DEPTH];
  logic [scsplit_pkg::QPTR_W-1:0]      wptr_r, wptr_nxt;
  logic [scsplit_pkg::QPTR_W-1:0]      rptr_r, rptr_nxt;
  logic [scsplit_pkg::QCNT_W-1:0]      count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign not_full  = (count_r != scsplit_pkg::QCNT_W'(scsplit_pkg::QUEUE_DEPTH));
  assign head_item = slot_r[rptr_r];

  // Pointer and occupancy update
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == scsplit_pkg::QPTR_W'(scsplit_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == scsplit_pkg::QPTR_W'(scsplit_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload slots, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_item;
    end
  end

endmodule

[rtl/scsplit_back.sv]
module scsplit_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  scsplit_pkg::item_t  item,
  output logic                item_pop,
  scsplit_out_if.source       out_chan
);

  logic        out_valid_r;
  logic [2:0]  kind_r;
  logic [7:0]  data_r;
  logic        start_r;
  logic        dropped_r;
  logic [7:0]  otype_r, ocount_r;
  logic [31:0] oval_r, otlo_r, othi_r;

  // Record fields gathered as the bytes stream by
  logic [7:0]  type_r, count_r;
  logic [31:0] val_r, tlo_r, thi_r;

  logic        absorb;
  logic        complete;
  logic [1:0]  val_off, tlo_off, thi_off;

  assign item_pop = item_valid && (!out_valid_r || out_chan.ready);
  assign absorb   = (item.kind == scsplit_pkg::KIND_ABSORBED);
  assign complete = (item.kind == scsplit_pkg::KIND_COMPLETE);
  assign val_off  = 2'(item.pos - scsplit_pkg::FILL_W'(scsplit_pkg::VALUE_POS));
  assign tlo_off  = 2'(item.pos - scsplit_pkg::FILL_W'(scsplit_pkg::TLO_POS));
  assign thi_off  = 2'(item.pos - scsplit_pkg::FILL_W'(scsplit_pkg::THI_POS));

  // Capture the record bytes that feed result fields
  always_ff @(posedge clk) begin
    if (item_pop && absorb) begin
      if (item.pos == scsplit_pkg::FILL_W'(scsplit_pkg::TYPE_POS)) begin
        type_r <= item.data_byte;
      end
      if (item.pos == scsplit_pkg::FILL_W'(scsplit_pkg::COUNTER_POS)) begin
        count_r <= item.data_byte;
      end
      if (item.pos >= scsplit_pkg::FILL_W'(scsplit_pkg::VALUE_POS) &&
          item.pos <  scsplit_pkg::FILL_W'(scsplit_pkg::VALUE_POS + 4)) begin
        val_r[8*val_off +: 8] <= item.data_byte;
      end
      if (item.pos >= scsplit_pkg::FILL_W'(scsplit_pkg::TLO_POS) &&
          item.pos <  scsplit_pkg::FILL_W'(scsplit_pkg::TLO_POS + 4)) begin
        tlo_r[8*tlo_off +: 8] <= item.data_byte;
      end
      if (item.pos >= scsplit_pkg::FILL_W'(scsplit_pkg::THI_POS) &&
          item.pos <  scsplit_pkg::FILL_W'(scsplit_pkg::THI_POS + 4)) begin
        thi_r[8*thi_off +: 8] <= item.data_byte;
      end
    end
  end

  // Output register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload; record fields only on a complete record
  always_ff @(posedge clk) begin
    if (item_pop) begin
      kind_r    <= item.kind;
      data_r    <= item.data_byte;
      start_r   <= item.unit_start;
      dropped_r <= item.incomplete_dropped;
      otype_r   <= complete ? type_r  : '0;
      ocount_r  <= complete ? count_r : '0;
      oval_r    <= complete ? val_r   : '0;
      otlo_r    <= complete ? tlo_r   : '0;
      othi_r    <= complete ? thi_r   : '0;
    end
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.kind               = kind_r;
  assign out_chan.data_byte          = data_r;
  assign out_chan.unit_start         = start_r;
  assign out_chan.incomplete_dropped = dropped_r;
  assign out_chan.record_type        = otype_r;
  assign out_chan.record_counter     = ocount_r;
  assign out_chan.record_value       = oval_r;
  assign out_chan.record_time_low    = otlo_r;
  assign out_chan.record_time_high   = othi_r;

endmodule

[rtl/start_code_splitter_record_extractor.sv]
// Path: a byte transferred in is written into the queue and then moved into the output
// register, from which it is transferred out.
// Throughput: one byte per cycle sustained; while a result waits, the two-entry queue
// takes two more bytes and then the input stalls.
// Reset (rst_n, synchronous, active low): history bytes AD BE EF, video mode, no
// partial record, no error held, queue and output empty.
module start_code_splitter_record_extractor (
  input  logic          clk,
  input  logic          rst_n,
  scsplit_in_if.sink    in_chan,
  scsplit_out_if.source out_chan
);

  scsplit_pkg::item_t front_item;
  scsplit_pkg::item_t head_item;
  logic               in_accept;
  logic               q_not_empty;
  logic               q_not_full;
  logic               q_pop;

  assign in_chan.ready = q_not_full;
  assign in_accept     = in_chan.valid && q_not_full;

  // Classify bytes and track unit state
  scsplit_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .stream_byte (in_chan.stream_byte),
    .item        (front_item)
  );

  // Decoupling queue
  scsplit_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_item (front_item),
    .pop       (q_pop),
    .head_item (head_item),
    .not_empty (q_not_empty),
    .not_full  (q_not_full)
  );

  // Gather record fields and drive results
  scsplit_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_not_empty),
    .item       (head_item),
    .item_pop   (q_pop),
    .out_chan   (out_chan)
  );

endmodule

[tb/sv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 1850;
  localparam int HOLD_AT_CYCLE = 1500;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_PRINTS    = 100;
  localparam int CONTENT_LEN   = scsplit_pkg::RECORD_LENGTH - 4;

  // Header, record fill and abandoned record cases, run before the random part
  localparam int DIRECTED_LEN = 22;
  localparam logic [7:0] DIRECTED_BYTES [DIRECTED_LEN] = '{
    8'h00, 8'hFF, 8'h01,
    8'h00, 8'h00, 8'h01, 8'h7F, 8'h5A,
    8'h00, 8'h00, 8'h01, 8'h80, 8'hFF, 8'h00,
    8'h00, 8'h00, 8'h01, 8'hFF,
    8'h00, 8'h00, 8'h01, 8'h00
  };

  typedef struct {
    scsplit_pkg::kind_t kind;
    logic [7:0]         data_byte;
    logic               unit_start;
    logic               incomplete_dropped;
    logic [7:0]         record_type;
    logic [7:0]         record_counter;
    logic [31:0]        record_value;
    logic [31:0]        record_time_low;
    logic [31:0]        record_time_high;
  } split_result_t;

  // Tracks splitter state per accepted byte and checks outputs in order
  class splitter_scoreboard;
    logic [23:0]   history;
    logic          tele_mode;
    logic [7:0]    store [scsplit_pkg::RECORD_LENGTH];
    int            fill;
    logic          err_hold;
    split_result_t pending_results [$];
    int            errors;
    int            results_seen;

    function new();
      history      = scsplit_pkg::RECENT_RESET;
      tele_mode    = 1'b0;
      fill         = 0;
      err_hold     = 1'b0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function logic [31:0] le_word(int pos);
      return {store[pos+3], store[pos+2], store[pos+1], store[pos]};
    endfunction

    function split_result_t classify_byte(logic [7:0] b);
      split_result_t r;
      logic          hdr;
      hdr = (history == scsplit_pkg::START_PREFIX);
      history = {history[15:0], b};
      r.kind               = scsplit_pkg::KIND_VIDEO;
      r.data_byte          = b;
      r.unit_start         = hdr;
      r.incomplete_dropped = 1'b0;
      r.record_type        = '0;
      r.record_counter     = '0;
      r.record_value       = '0;
      r.record_time_low    = '0;
      r.record_time_high   = '0;
      // unit header: new mode, partial record thrown away
      if (hdr) begin
        if (tele_mode && fill != 0) r.incomplete_dropped = 1'b1;
        fill      = 0;
        err_hold  = 1'b0;
        tele_mode = b[scsplit_pkg::HEADER_TELEMETRY_BIT];
      end
      if (!tele_mode) begin
        r.kind = scsplit_pkg::KIND_VIDEO;
      end else if (err_hold) begin
        r.kind = scsplit_pkg::KIND_DISCARDED;
      end else begin
        if (fill >= scsplit_pkg::RECORD_LENGTH) fill = 0;
        store[fill] = b;
        fill++;
        r.kind = scsplit_pkg::KIND_ABSORBED;
        if (fill == scsplit_pkg::RECORD_LENGTH) begin
          fill = 0;
          if (store[scsplit_pkg::RECORD_LENGTH-3] == 8'h00 &&
              store[scsplit_pkg::RECORD_LENGTH-2] == 8'h00 &&
              store[scsplit_pkg::RECORD_LENGTH-1] == 8'h01) begin
            r.kind             = scsplit_pkg::KIND_COMPLETE;
            r.record_type      = store[scsplit_pkg::TYPE_POS];
            r.record_counter   = store[scsplit_pkg::COUNTER_POS];
            r.record_value     = le_word(scsplit_pkg::VALUE_POS);
            r.record_time_low  = le_word(scsplit_pkg::TLO_POS);
            r.record_time_high = le_word(scsplit_pkg::THI_POS);
          end else begin
            r.kind   = scsplit_pkg::KIND_MISALIGNED;
            err_hold = 1'b1;
          end
        end
      end
      return r;
    endfunction

    function void note_byte(logic [7:0] b);
      pending_results.push_back(classify_byte(b));
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("[%0t] result %0d: %s got %h expected %h", $realtime, results_seen,
                 what, got, want);
    endtask

    task check_output(split_result_t got);
      split_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report("unexpected transfer, byte", 32'(got.data_byte), 32'd0);
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind) report("kind", 32'(got.kind), 32'(want.kind));
      if (got.data_byte !== want.data_byte)
        report("data_byte", 32'(got.data_byte), 32'(want.data_byte));
      if (got.unit_start !== want.unit_start)
        report("unit_start", 32'(got.unit_start), 32'(want.unit_start));
      if (got.incomplete_dropped !== want.incomplete_dropped)
        report("incomplete_dropped", 32'(got.incomplete_dropped),
               32'(want.incomplete_dropped));
      if (got.record_type !== want.record_type)
        report("record_type", 32'(got.record_type), 32'(want.record_type));
      if (got.record_counter !== want.record_counter)
        report("record_counter", 32'(got.record_counter), 32'(want.record_counter));
      if (got.record_value !== want.record_value)
        report("record_value", got.record_value, want.record_value);
      if (got.record_time_low !== want.record_time_low)
        report("record_time_low", got.record_time_low, want.record_time_low);
      if (got.record_time_high !== want.record_time_high)
        report("record_time_high", got.record_time_high, want.record_time_high);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycles = 0;
  bit   hold_done = 1'b0;

  scsplit_in_if  in_if ();
  scsplit_out_if out_if ();

  splitter_scoreboard sb = new();

  start_code_splitter_record_extractor dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #10 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Output monitor
  always @(posedge clk) begin
    split_result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.kind               = scsplit_pkg::kind_t'(out_if.kind);
      got.data_byte          = out_if.data_byte;
      got.unit_start         = out_if.unit_start;
      got.incomplete_dropped = out_if.incomplete_dropped;
      got.record_type        = out_if.record_type;
      got.record_counter     = out_if.record_counter;
      got.record_value       = out_if.record_value;
      got.record_time_low    = out_if.record_time_low;
      got.record_time_high   = out_if.record_time_high;
      sb.check_output(got);
    end
  end

  // Receiver: stall patterns in epochs, plus one long hold-off
  initial begin
    int mode;
    int run_len;
    int period;
    int duty;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (!hold_done && cycles > HOLD_AT_CYCLE) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      mode    = $urandom_range(0, 3);
      run_len = $urandom_range(20, 200);
      period  = $urandom_range(2, 7);
      duty    = $urandom_range(1, period - 1);
      for (int i = 0; i < run_len; i++) begin
        case (mode)
          0: begin
            out_if.ready <= 1'b1;
          end
          1: begin
            out_if.ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_if.ready <= ((i % period) < duty);
          end
          default: begin
            out_if.ready <= ($urandom_range(0, 3) == 0);
          end
        endcase
        @(negedge clk);
      end
    end
  end

  // Sender state
  int          burst_left = 0;
  int          items_sent = 0;
  logic [23:0] stream_tail = scsplit_pkg::RECENT_RESET;

  // Offer one byte; called just after a falling edge, returns just after one
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) :
                   $urandom_range(1, 8);
    end
    in_if.valid       <= 1'b1;
    in_if.stream_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_byte(b);
    stream_tail = {stream_tail[15:0], b};
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Record content byte that never completes a start code
  task automatic send_content(input logic [7:0] b);
    if (stream_tail[15:0] == 16'h0000 && b == 8'h01) b = 8'h02;
    send_byte(b);
  endtask

  task automatic send_start();
    if (stream_tail != scsplit_pkg::START_PREFIX) begin
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h01);
    end
  endtask

  function automatic logic [7:0] content_value();
    case ($urandom_range(0, 9))
      7: return 8'h00;
      8: return 8'hFF;
      9: return 8'h01;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One record after a start code; aligned ends in 00 00 01
  task automatic send_record(input bit aligned);
    send_byte(8'h80 | 8'($urandom_range(0, 127)));
    for (int i = 0; i < CONTENT_LEN; i++) send_content(content_value());
    if (aligned) begin
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h01);
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          send_content(8'h00); send_content(8'h00); send_content(8'h02);
        end
        1: begin
          send_content(8'h00); send_content(8'h01); send_content(8'h01);
        end
        2: begin
          send_content(8'h01); send_content(8'h00); send_content(8'h01);
        end
        default: begin
          send_content(content_value()); send_content(content_value());
          send_content(8'h03);
        end
      endcase
    end
  endtask

  initial begin
    int pick;
    int n;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.stream_byte = 8'h00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_LEN; i++) send_byte(DIRECTED_BYTES[i]);

    // Mostly well-formed telemetry units, mixed at random with video, broken records and noise
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_start();
        n = $urandom_range(1, 3);
        for (int r = 0; r < n; r++) send_record($urandom_range(0, 9) != 0);
      end else if (pick < 70) begin
        send_start();
        send_byte(8'($urandom_range(0, 127)));
        n = $urandom_range(0, 30);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 82) begin
        // record cut short by the next start code
        send_start();
        send_byte(8'h80 | 8'($urandom_range(0, 127)));
        n = ($urandom_range(0, 3) == 0) ? scsplit_pkg::RECORD_LENGTH - 2 :
            $urandom_range(0, scsplit_pkg::RECORD_LENGTH - 2);
        repeat (n) send_content(content_value());
        send_start();
      end else if (pick < 90) begin
        // misaligned record, then bytes dropped until the next unit
        send_start();
        send_record(1'b0);
        n = $urandom_range(0, 8);
        repeat (n) send_content(content_value());
      end else begin
        n = $urandom_range(1, 20);
        repeat (n) begin
          case ($urandom_range(0, 4))
            0: send_byte(8'h00);
            1: send_byte(8'h01);
            2: send_byte(8'h80);
            default: send_byte(8'($urandom_range(0, 255)));
          endcase
        end
      end
    end
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
